### hw/rtl/wkm_pkg.sv
// ----------------------------------------------------------------------------
// wkm_pkg
// shared constants, payload types and unit interfaces of the k-means core
// ----------------------------------------------------------------------------
package wkm_pkg;

  localparam int MaxSamples  = 256;
  localparam int MaxClusters = 8;
  localparam int Dims        = 4;
  localparam int FeatBits    = 16;

  localparam int SampleAw  = $clog2(MaxSamples);
  localparam int CountW    = SampleAw + 1;
  localparam int ClusterW  = $clog2(MaxClusters);
  localparam int KW        = ClusterW + 1;
  localparam int DimW      = $clog2(Dims + 1);
  localparam int DimIdxW   = (Dims > 1) ? $clog2(Dims) : 1;
  localparam int WeightW   = 12;
  localparam int DistW     = 2 * FeatBits + WeightW + $clog2(Dims) + 1;
  localparam int SumW      = FeatBits + SampleAw;
  localparam int ChgW      = $clog2(MaxClusters * Dims + 1);
  localparam int DivCntW   = $clog2(SumW);
  localparam int LaneLat   = 4;
  localparam int MergeLat  = ClusterW;
  localparam int PipeLat   = LaneLat + MergeLat;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 12;

  localparam logic [WeightW-1:0] UnitWeight = WeightW'(256);

  typedef logic signed [FeatBits-1:0] feat_t;
  typedef feat_t [Dims-1:0]           vec_t;
  typedef logic [DistW-1:0]           dist_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_LABEL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_RESULT = 2'd1,
    KIND_LABEL  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLUSTERS  = 3'd0,
    REG_MAX_EPOCH = 3'd1,
    REG_MIN_CHG   = 3'd2,
    REG_DIMS      = 3'd3,
    REG_WEIGHT0   = 3'd4,
    REG_WEIGHT1   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         sample_index;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         cluster_index;
    logic signed [15:0] centroid_0;
    logic signed [15:0] centroid_1;
    logic signed [15:0] centroid_2;
    logic signed [15:0] centroid_3;
    logic [8:0]         member_count;
    logic [7:0]         epochs_run;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   num;
    logic [CountW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/wkm_ram.sv
// ----------------------------------------------------------------------------
// wkm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wkm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/wkm_div.sv
// ----------------------------------------------------------------------------
// wkm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wkm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wkm_pkg::div_req_t req_i,
  output wkm_pkg::div_rsp_t rsp_o
);
  import wkm_pkg::*;

  logic                busy_q, done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [SumW-1:0]     q_q;
  logic [CountW-1:0]   rem_q, den_q;
  logic [CountW:0]     rem_sh, rem_nxt;
  logic                ge;

  assign rem_sh  = {rem_q, q_q[SumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        q_q    <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
        cnt_q  <= DivCntW'(SumW - 1);
      end else if (busy_q) begin
        rem_q <= rem_nxt[CountW-1:0];
        q_q   <= {q_q[SumW-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

  // a new division never starts on top of one in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider restarted while busy");
  // done only at the end of a running division
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(done_q) |-> $past(busy_q))
    else $error("divider done without a division");
  // zero divisor is never requested
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> req_i.den != '0)
    else $error("divider started with zero divisor");

endmodule

### hw/rtl/wkm_lane.sv
// ----------------------------------------------------------------------------
// wkm_lane
// weighted squared distance of one sample to one centroid, four stages
// ----------------------------------------------------------------------------
module wkm_lane (
  input  logic                         clk_i,
  input  wkm_pkg::vec_t                sample_i,
  input  wkm_pkg::vec_t                centroid_i,
  input  logic [wkm_pkg::Dims-1:0]     dim_en_i,
  input  logic [wkm_pkg::WeightW-1:0]  weight0_i,
  input  logic [wkm_pkg::WeightW-1:0]  weight1_i,
  output wkm_pkg::dist_t               dist_o
);
  import wkm_pkg::*;

  logic signed [FeatBits:0]            diff_q [Dims];
  logic [2*FeatBits-1:0]               sq_q   [Dims];
  logic [2*FeatBits+WeightW-1:0]       wsq_q  [Dims];
  logic [FeatBits-1:0]                 mag    [Dims];
  logic [WeightW-1:0]                  wt     [Dims];
  dist_t                               acc;

  always_comb begin
    for (int d = 0; d < Dims; d++) begin
      mag[d] = diff_q[d][FeatBits] ? FeatBits'(-diff_q[d]) : diff_q[d][FeatBits-1:0];
      if (!dim_en_i[d])  wt[d] = '0;
      else if (d == 0)   wt[d] = weight0_i;
      else if (d == 1)   wt[d] = weight1_i;
      else               wt[d] = UnitWeight;
    end
  end

  always_comb begin
    acc = '0;
    for (int d = 0; d < Dims; d++) begin
      acc = acc + DistW'(wsq_q[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < Dims; d++) begin
      diff_q[d] <= (FeatBits+1)'(sample_i[d]) - (FeatBits+1)'(centroid_i[d]);
      sq_q[d]   <= mag[d] * mag[d];
      wsq_q[d]  <= wt[d] * sq_q[d];
    end
    dist_o <= acc;
  end

endmodule

### hw/rtl/wkm_merge.sv
// ----------------------------------------------------------------------------
// wkm_merge
// registered min tree over the lane distances, lowest index wins ties
// ----------------------------------------------------------------------------
module wkm_merge (
  input  logic                              clk_i,
  input  logic [wkm_pkg::MaxClusters-1:0]   lane_en_i,
  input  wkm_pkg::dist_t [wkm_pkg::MaxClusters-1:0] dist_i,
  output logic [wkm_pkg::ClusterW-1:0]      best_o
);
  import wkm_pkg::*;

  localparam int Half = MaxClusters / 2;

  logic                v_q [MergeLat][Half];
  dist_t               d_q [MergeLat][Half];
  logic [ClusterW-1:0] i_q [MergeLat][Half];
  logic                v_d [MergeLat][Half];
  dist_t               d_d [MergeLat][Half];
  logic [ClusterW-1:0] i_d [MergeLat][Half];

  always_comb begin
    logic                av, bv;
    dist_t               ad, bd;
    logic [ClusterW-1:0] ai, bi;
    for (int l = 0; l < MergeLat; l++) begin
      for (int e = 0; e < Half; e++) begin
        v_d[l][e] = 1'b0;
        d_d[l][e] = '0;
        i_d[l][e] = '0;
        if (e < (MaxClusters >> (l + 1))) begin
          if (l == 0) begin
            av = lane_en_i[2*e];   ad = dist_i[2*e];   ai = ClusterW'(2*e);
            bv = lane_en_i[2*e+1]; bd = dist_i[2*e+1]; bi = ClusterW'(2*e+1);
          end else begin
            av = v_q[l-1][2*e];   ad = d_q[l-1][2*e];   ai = i_q[l-1][2*e];
            bv = v_q[l-1][2*e+1]; bd = d_q[l-1][2*e+1]; bi = i_q[l-1][2*e+1];
          end
          if (bv && (!av || bd < ad)) begin
            v_d[l][e] = bv; d_d[l][e] = bd; i_d[l][e] = bi;
          end else begin
            v_d[l][e] = av; d_d[l][e] = ad; i_d[l][e] = ai;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    d_q <= d_d;
    i_q <= i_d;
  end

  assign best_o = i_q[MergeLat-1][0];

endmodule

### hw/rtl/weighted_kmeans_clustering_core.sv
// ----------------------------------------------------------------------------
// weighted_kmeans_clustering_core
// weighted lloyd k-means over a loaded sample store, one lane per cluster
// ----------------------------------------------------------------------------
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+---------------------------
//  command   | start_i, item_i, busy_o              | word taken when start_i & !busy_o
//  result    | result_valid_o, result_o             | one-cycle strobe, no backpressure
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i      | written on any edge with cfg_we_i
//
//  clear and load do not raise busy; the ack follows in the next cycle
//  label read: through the label ram registered read port, then ST_LABEL registers the word
//  run: one divide for the initial step, a read and a write state per initial centroid,
//    then per epoch streaming through the lanes and merge tree,
//    plus one divide per centroid element of each non-empty cluster in the update pass
//  after reset the core is ready at once; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module weighted_kmeans_clustering_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  wkm_pkg::in_t                  item_i,
  output logic                          result_valid_o,
  output wkm_pkg::out_t                 result_o,
  input  logic                          cfg_we_i,
  input  logic [wkm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wkm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wkm_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_LABEL    = 10'b0000000010,
    ST_STEP     = 10'b0000000100,
    ST_INIT_RD  = 10'b0000001000,
    ST_INIT_WR  = 10'b0000010000,
    ST_ASSIGN   = 10'b0000100000,
    ST_DRAIN    = 10'b0001000000,
    ST_UPDATE   = 10'b0010000000,
    ST_UPD_WAIT = 10'b0100000000,
    ST_EMIT     = 10'b1000000000
  } state_e;

  typedef logic signed [SumW-1:0] sum_t;

  // configuration registers
  logic [3:0]         k_cfg_q;
  logic [7:0]         max_ep_q;
  logic [5:0]         min_ch_q;
  logic [2:0]         dims_q;
  logic [WeightW-1:0] w0_q, w1_q;

  state_e               state_q;
  logic [CountW-1:0]    count_q, step_q, j_q;
  logic [KW-1:0]        ci_q;
  logic [DimIdxW-1:0]   cd_q;
  logic [7:0]           epochs_q;
  logic [ChgW-1:0]      changed_q;
  logic [MaxSamples-1:0] lbl_valid_q;
  logic [SampleAw-1:0]  lbl_idx_q;
  vec_t                 centroid_q [MaxClusters];
  sum_t                 sum_q [MaxClusters][Dims];
  logic [CountW-1:0]    mem_q [MaxClusters];

  // read stream into the lanes and the matching sample / index line
  logic                 rv_q;
  logic [SampleAw-1:0]  rj_q;
  logic [PipeLat-1:0]   p_v_q;
  vec_t                 p_s_q [PipeLat];
  logic [SampleAw-1:0]  p_j_q [PipeLat];

  out_t                 out_q;
  logic                 out_v_q;

  // derived controls
  logic [KW-1:0]         k_sat;
  logic [DimW-1:0]       nd_sat;
  logic [Dims-1:0]       dim_en;
  logic [MaxClusters-1:0] lane_en;

  always_comb begin
    if (k_cfg_q == '0)                  k_sat = KW'(1);
    else if (32'(k_cfg_q) > MaxClusters) k_sat = KW'(MaxClusters);
    else                                k_sat = KW'(k_cfg_q);
    if (dims_q == '0)                   nd_sat = DimW'(1);
    else if (32'(dims_q) > Dims)        nd_sat = DimW'(Dims);
    else                                nd_sat = DimW'(dims_q);
    for (int d = 0; d < Dims; d++)        dim_en[d]  = d < 32'(nd_sat);
    for (int i = 0; i < MaxClusters; i++) lane_en[i] = i < 32'(k_sat);
  end

  logic accept, is_run, is_load;
  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_load  = accept && (cmd_e'(item_i.command) == CMD_LOAD);
  assign is_run   = accept && (cmd_e'(item_i.command) == CMD_RUN);
  assign busy_o   = state_q != ST_IDLE;

  // sample store
  vec_t                load_vec, samp_rdata;
  logic                samp_we;
  logic [SampleAw-1:0] samp_raddr;
  logic [ClusterW+CountW-1:0] init_addr;

  assign load_vec[0] = item_i.feature_0;
  assign load_vec[1] = item_i.feature_1;
  assign load_vec[2] = item_i.feature_2;
  assign load_vec[3] = item_i.feature_3;
  assign samp_we     = is_load && (32'(count_q) < MaxSamples);
  assign init_addr   = ci_q[ClusterW-1:0] * step_q;

  always_comb begin
    samp_raddr = j_q[SampleAw-1:0];
    if (state_q == ST_INIT_RD) begin
      samp_raddr = (init_addr >= (ClusterW+CountW)'(count_q)) ? '0
                                                              : init_addr[SampleAw-1:0];
    end
  end

  wkm_ram #(
    .Width ($bits(vec_t)),
    .Depth (MaxSamples)
  ) u_samples (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (count_q[SampleAw-1:0]),
    .wdata_i (load_vec),
    .raddr_i (samp_raddr),
    .rdata_o (samp_rdata)
  );

  // one distance lane per cluster
  dist_t [MaxClusters-1:0] lane_dist;
  logic [ClusterW-1:0]     best;

  for (genvar g = 0; g < MaxClusters; g++) begin : g_lane
    wkm_lane u_lane (
      .clk_i      (clk_i),
      .sample_i   (samp_rdata),
      .centroid_i (centroid_q[g]),
      .dim_en_i   (dim_en),
      .weight0_i  (w0_q),
      .weight1_i  (w1_q),
      .dist_o     (lane_dist[g])
    );
  end

  wkm_merge u_merge (
    .clk_i     (clk_i),
    .lane_en_i (lane_en),
    .dist_i    (lane_dist),
    .best_o    (best)
  );

  // sample leaving the merge tree together with its winner
  logic                fin_v;
  vec_t                fin_s;
  logic [SampleAw-1:0] fin_j;
  assign fin_v = p_v_q[PipeLat-1];
  assign fin_s = p_s_q[PipeLat-1];
  assign fin_j = p_j_q[PipeLat-1];

  // label store, valid bit per entry so clear is instant
  logic [ClusterW-1:0] lbl_rdata;

  wkm_ram #(
    .Width (ClusterW),
    .Depth (MaxSamples)
  ) u_labels (
    .clk_i   (clk_i),
    .we_i    (fin_v),
    .waddr_i (fin_j),
    .wdata_i (best),
    .raddr_i (SampleAw'(item_i.sample_index)),
    .rdata_o (lbl_rdata)
  );

  // shared divider: initial step and centroid means
  div_req_t div_req;
  div_rsp_t div_rsp;
  sum_t     upd_sum;
  logic [SumW-1:0] upd_mag, upd_mean;
  feat_t    upd_m;

  assign upd_sum  = sum_q[ci_q[ClusterW-1:0]][cd_q];
  assign upd_mag  = upd_sum[SumW-1] ? SumW'(-upd_sum) : SumW'(upd_sum);
  assign upd_mean = upd_sum[SumW-1] ? -div_rsp.quot : div_rsp.quot;
  assign upd_m    = upd_mean[FeatBits-1:0];

  always_comb begin
    div_req = '0;
    if (is_run) begin
      div_req.start = count_q != '0;
      div_req.num   = SumW'(count_q);
      div_req.den   = CountW'(k_sat);
    end else if (state_q == ST_UPDATE && ci_q != k_sat &&
                 mem_q[ci_q[ClusterW-1:0]] != '0) begin
      div_req.start = 1'b1;
      div_req.num   = upd_mag;
      div_req.den   = mem_q[ci_q[ClusterW-1:0]];
    end
  end

  wkm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // payload line next to the lanes
  always_ff @(posedge clk_i) begin
    p_s_q[0] <= samp_rdata;
    p_j_q[0] <= rj_q;
    for (int n = 1; n < PipeLat; n++) begin
      p_s_q[n] <= p_s_q[n-1];
      p_j_q[n] <= p_j_q[n-1];
    end
  end

  logic last_ci, last_cd, stop_run;
  assign last_ci  = ci_q == k_sat - 1'b1;
  assign last_cd  = 32'(cd_q) == 32'(nd_sat) - 1;
  assign stop_run = (8'(changed_q) <= 8'(min_ch_q)) || (epochs_q == max_ep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q     <= 4'd2;
      max_ep_q    <= 8'd16;
      min_ch_q    <= '0;
      dims_q      <= 3'd4;
      w0_q        <= '0;
      w1_q        <= UnitWeight;
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      j_q         <= '0;
      ci_q        <= '0;
      cd_q        <= '0;
      epochs_q    <= '0;
      changed_q   <= '0;
      lbl_valid_q <= '0;
      lbl_idx_q   <= '0;
      rv_q        <= 1'b0;
      rj_q        <= '0;
      p_v_q       <= '0;
      out_q       <= '0;
      out_v_q     <= 1'b0;
      for (int i = 0; i < MaxClusters; i++) begin
        centroid_q[i] <= '0;
        mem_q[i]      <= '0;
        for (int d = 0; d < Dims; d++) sum_q[i][d] <= '0;
      end
    end else begin
      out_v_q <= 1'b0;
      out_q   <= '0;
      rv_q    <= 1'b0;
      p_v_q   <= {p_v_q[PipeLat-2:0], rv_q};

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_CLUSTERS:  k_cfg_q  <= cfg_data_i[3:0];
          REG_MAX_EPOCH: max_ep_q <= cfg_data_i[7:0];
          REG_MIN_CHG:   min_ch_q <= cfg_data_i[5:0];
          REG_DIMS:      dims_q   <= cfg_data_i[2:0];
          REG_WEIGHT0:   w0_q     <= cfg_data_i;
          REG_WEIGHT1:   w1_q     <= cfg_data_i;
          default: ;
        endcase
      end

      // accumulate the winner of the sample leaving the tree
      if (fin_v) begin
        mem_q[best]       <= mem_q[best] + 1'b1;
        lbl_valid_q[fin_j] <= 1'b1;
        for (int d = 0; d < Dims; d++) begin
          sum_q[best][d] <= sum_q[best][d] + SumW'(fin_s[d]);
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_v_q           <= 1'b1;
            out_q.last_result <= 1'b1;
            case (cmd_e'(item_i.command))
              CMD_CLEAR: begin
                count_q     <= '0;
                lbl_valid_q <= '0;
                out_q.kind  <= KIND_ACK;
              end
              CMD_LOAD: begin
                if (32'(count_q) >= MaxSamples) begin
                  out_q.kind <= KIND_ERROR;
                end else begin
                  count_q    <= count_q + 1'b1;
                  out_q.kind <= KIND_ACK;
                end
              end
              CMD_LABEL: begin
                if (32'(item_i.sample_index) >= MaxSamples) begin
                  out_q.kind <= KIND_ERROR;
                end else begin
                  out_v_q   <= 1'b0;
                  lbl_idx_q <= SampleAw'(item_i.sample_index);
                  state_q   <= ST_LABEL;
                end
              end
              CMD_RUN: begin
                if (count_q == '0) begin
                  out_q.kind <= KIND_ERROR;
                end else begin
                  out_v_q  <= 1'b0;
                  epochs_q <= '0;
                  state_q  <= ST_STEP;
                end
              end
              default: ;
            endcase
          end
        end

        ST_LABEL: begin
          out_v_q             <= 1'b1;
          out_q.kind          <= KIND_LABEL;
          out_q.cluster_index <= lbl_valid_q[lbl_idx_q] ? 3'(lbl_rdata) : '0;
          out_q.last_result   <= 1'b1;
          state_q             <= ST_IDLE;
        end

        ST_STEP: begin
          if (div_rsp.done) begin
            step_q  <= div_rsp.quot[CountW-1:0];
            ci_q    <= '0;
            state_q <= ST_INIT_RD;
          end
        end

        ST_INIT_RD: state_q <= ST_INIT_WR;

        ST_INIT_WR: begin
          centroid_q[ci_q[ClusterW-1:0]] <= samp_rdata;
          mem_q[ci_q[ClusterW-1:0]]      <= '0;
          if (last_ci) begin
            ci_q <= '0;
            if (max_ep_q == '0) begin
              state_q <= ST_EMIT;
            end else begin
              epochs_q <= epochs_q + 1'b1;
              j_q      <= '0;
              state_q  <= ST_ASSIGN;
              for (int i = 0; i < MaxClusters; i++) begin
                mem_q[i] <= '0;
                for (int d = 0; d < Dims; d++) sum_q[i][d] <= '0;
              end
            end
          end else begin
            ci_q    <= ci_q + 1'b1;
            state_q <= ST_INIT_RD;
          end
        end

        // stream every sample through the lanes, one per cycle
        ST_ASSIGN: begin
          rv_q <= 1'b1;
          rj_q <= j_q[SampleAw-1:0];
          j_q  <= j_q + 1'b1;
          if (j_q == count_q - 1'b1) state_q <= ST_DRAIN;
        end

        ST_DRAIN: begin
          if (!rv_q && p_v_q == '0) begin
            ci_q      <= '0;
            cd_q      <= '0;
            changed_q <= '0;
            state_q   <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (ci_q == k_sat) begin
            ci_q <= '0;
            if (stop_run) begin
              state_q <= ST_EMIT;
            end else begin
              epochs_q <= epochs_q + 1'b1;
              j_q      <= '0;
              state_q  <= ST_ASSIGN;
              for (int i = 0; i < MaxClusters; i++) begin
                mem_q[i] <= '0;
                for (int d = 0; d < Dims; d++) sum_q[i][d] <= '0;
              end
            end
          end else if (mem_q[ci_q[ClusterW-1:0]] == '0) begin
            // empty cluster keeps its centroid
            ci_q <= ci_q + 1'b1;
          end else begin
            state_q <= ST_UPD_WAIT;
          end
        end

        ST_UPD_WAIT: begin
          if (div_rsp.done) begin
            if (upd_m != centroid_q[ci_q[ClusterW-1:0]][cd_q]) begin
              centroid_q[ci_q[ClusterW-1:0]][cd_q] <= upd_m;
              changed_q <= changed_q + 1'b1;
            end
            if (last_cd) begin
              cd_q <= '0;
              ci_q <= ci_q + 1'b1;
            end else begin
              cd_q <= cd_q + 1'b1;
            end
            state_q <= ST_UPDATE;
          end
        end

        ST_EMIT: begin
          out_v_q             <= 1'b1;
          out_q.kind          <= KIND_RESULT;
          out_q.cluster_index <= 3'(ci_q[ClusterW-1:0]);
          out_q.centroid_0    <= dim_en[0] ? centroid_q[ci_q[ClusterW-1:0]][0] : '0;
          out_q.centroid_1    <= dim_en[1] ? centroid_q[ci_q[ClusterW-1:0]][1] : '0;
          out_q.centroid_2    <= dim_en[2] ? centroid_q[ci_q[ClusterW-1:0]][2] : '0;
          out_q.centroid_3    <= dim_en[3] ? centroid_q[ci_q[ClusterW-1:0]][3] : '0;
          out_q.member_count  <= 9'(mem_q[ci_q[ClusterW-1:0]]);
          out_q.epochs_run    <= epochs_q;
          out_q.last_result   <= last_ci;
          if (last_ci) begin
            state_q <= ST_IDLE;
          end else begin
            ci_q <= ci_q + 1'b1;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

  // samples only flow through the lanes during the assign pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_v_q != '0) |-> (state_q == ST_ASSIGN || state_q == ST_DRAIN))
    else $error("lane pipeline active outside assign pass");
  // the word for the last cluster emitted is the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && last_ci) |=> (result_valid_o && result_o.last_result))
    else $error("run ended without final word");
  // cluster results never name a cluster beyond k
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.kind == KIND_RESULT) |->
      (KW'(result_o.cluster_index) < k_sat))
    else $error("cluster index beyond cluster count");
  // changed element count stays within the centroid table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(changed_q) <= MaxClusters * Dims)
    else $error("changed count overflow");

endmodule
